// ===== rtl/fpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_pkg
// shared codes, defaults and the record control type of the partition
// allocator
// ----------------------------------------------------------------------------
package fpba_pkg;

	localparam int PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// field widths fixed by the interface
	localparam int ACT_W    = 2;
	localparam int BIDX_W   = 4;
	localparam int AMOUNT_W = 16;
	localparam int MODE_W   = 2;
	localparam int BLK_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// actions
	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REQ  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

	// fit modes, anything else behaves as first fit
	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS   = 1'd1;

	// control part of the record walking down the cell row
	typedef struct packed {
		logic vld;
		logic is_read;
		logic have;
	} fpba_ctl_t;

endpackage

// ===== rtl/fpba_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_cell
// one partition: holds its size and used mark, updates the passing record
// ----------------------------------------------------------------------------
module fpba_cell #(
	parameter int SIZE_BITS = fpba_pkg::SIZE_BITS_DEF,
	parameter int IDX_W     = 4,
	parameter int CELL_ID   = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [fpba_pkg::MODE_W-1:0]  fit_mode,
	input  logic                         active,
	input  logic [SIZE_BITS-1:0]         want,
	input  fpba_pkg::fpba_ctl_t          ctl_in,
	input  logic [IDX_W-1:0]             idx_in,
	input  logic [SIZE_BITS-1:0]         size_in,
	output fpba_pkg::fpba_ctl_t          ctl_out,
	output logic [IDX_W-1:0]             idx_out,
	output logic [SIZE_BITS-1:0]         size_out,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_idx,
	input  logic [SIZE_BITS-1:0]         wr_size,
	input  logic                         wr_used
);

	logic [SIZE_BITS-1:0] size_q;
	logic                 used_q;
	fpba_pkg::fpba_ctl_t  ctl_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] best_q;
	logic                 mine;
	logic                 elig;
	logic                 take;

	assign mine = (idx_in == IDX_W'(CELL_ID));
	assign elig = active && !used_q && (size_q >= want);

	always_comb begin
		if (ctl_in.is_read) begin
			take = mine;
		end else begin
			case (fit_mode)
				fpba_pkg::FIT_BEST:  take = elig && (!ctl_in.have || size_q < size_in);
				fpba_pkg::FIT_WORST: take = elig && (!ctl_in.have || size_q > size_in);
				default:             take = elig && !ctl_in.have;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			ctl_q  <= '0;
		end else begin
			if (wr_en && wr_idx == IDX_W'(CELL_ID)) begin
				used_q <= wr_used;
			end
			ctl_q.vld     <= ctl_in.vld;
			ctl_q.is_read <= ctl_in.is_read;
			ctl_q.have    <= ctl_in.have || (ctl_in.vld && take);
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == IDX_W'(CELL_ID)) begin
			size_q <= wr_size;
		end
		idx_q  <= take ? IDX_W'(CELL_ID) : idx_in;
		best_q <= take ? size_q : size_in;
	end

	assign ctl_out  = ctl_q;
	assign idx_out  = idx_q;
	assign size_out = best_q;

endmodule

// ===== rtl/fit_policy_block_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_top
// partition allocator with first, best and worst fit, built as a row of
// partition cells that a search record walks through one cell per cycle
// ----------------------------------------------------------------------------
//
// channel   direction  ports                                        beat when
// command   in         start busy action block_index amount         start & !busy
//                      batch_end
// result    out        done granted chosen_index remaining          done
//                      batch_done
// config    in         cfg_we cfg_index cfg_wdata                   cfg_we
//
// a load beat gives its result in the cycle after it is taken; busy stays low
// a request or an in-range read injects a record into cell 0; the record
//   passes through every cell register in row order and leaves the last
//   cell, then the result register takes it; the next command can be taken
//   in the cycle the result shows, so the wait per item is set by the
//   length of the cell row
// reset clears the used marks, the registers and all control; partition
//   sizes are undefined until loaded
// results cannot be stalled: done is high for one cycle per command
//
module fit_policy_block_allocator_top #(
	parameter int PARTITIONS = fpba_pkg::PARTITIONS_DEF,
	parameter int SIZE_BITS  = fpba_pkg::SIZE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// command
	input  logic                              start,
	output logic                              busy,
	input  logic [fpba_pkg::ACT_W-1:0]        action,
	input  logic [fpba_pkg::BIDX_W-1:0]       block_index,
	input  logic [fpba_pkg::AMOUNT_W-1:0]     amount,
	input  logic                              batch_end,
	// result
	output logic                              done,
	output logic                              granted,
	output logic [fpba_pkg::BIDX_W-1:0]       chosen_index,
	output logic [fpba_pkg::AMOUNT_W-1:0]     remaining,
	output logic                              batch_done,
	// config
	input  logic                              cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpba_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

	// controller states
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                            state_q;
	logic [fpba_pkg::MODE_W-1:0]     fit_mode_q;
	logic [fpba_pkg::BLK_W-1:0]      blocks_q;

	// latched command
	logic [SIZE_BITS-1:0]            want_q;
	logic [fpba_pkg::BIDX_W-1:0]     bidx_q;
	logic                            bend_q;

	// result registers
	logic                            done_q;
	logic                            granted_q;
	logic [fpba_pkg::BIDX_W-1:0]     chosen_q;
	logic [fpba_pkg::AMOUNT_W-1:0]   rem_q;
	logic                            bdone_q;

	logic                            accept;
	logic                            in_range;
	logic [SIZE_BITS-1:0]            want_in;
	logic [SIZE_BITS-1:0]            want_bus;

	// cell row wiring, position j feeds cell j
	fpba_pkg::fpba_ctl_t             ctl_c  [PARTITIONS+1];
	logic [IDX_W-1:0]                idx_c  [PARTITIONS+1];
	logic [SIZE_BITS-1:0]            size_c [PARTITIONS+1];
	logic [PARTITIONS-1:0]           active;
	logic [PARTITIONS-1:0]           vld_vec;
	fpba_pkg::fpba_ctl_t             tail;

	// broadcast write into the row
	logic                            wr_en;
	logic [IDX_W-1:0]                wr_idx;
	logic [SIZE_BITS-1:0]            wr_size;
	logic                            wr_used;

	// next result
	logic                            res_fire;
	logic                            res_granted;
	logic [fpba_pkg::BIDX_W-1:0]     res_idx;
	logic [fpba_pkg::AMOUNT_W-1:0]   res_rem;
	logic                            res_bend;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q == ST_SCAN);
	assign in_range = (32'(block_index) < PARTITIONS);
	assign want_in  = SIZE_BITS'(amount);
	// cell 0 compares on the injection cycle against the live amount, the
	// later cells against the latched value
	assign want_bus = accept ? want_in : want_q;
	assign tail     = ctl_c[PARTITIONS];

	// record entering cell 0
	always_comb begin
		ctl_c[0].vld     = accept && (action == fpba_pkg::ACT_REQ ||
			(action == fpba_pkg::ACT_READ && in_range));
		ctl_c[0].is_read = (action == fpba_pkg::ACT_READ);
		ctl_c[0].have    = 1'b0;
		idx_c[0]         = IDX_W'(block_index);
		size_c[0]        = '0;
	end

	// search limit, saturates at the row length by construction
	genvar j;
	generate
		for (j = 0; j < PARTITIONS; j++) begin : g_row
			assign active[j]  = (32'(j) < 32'(blocks_q));
			assign vld_vec[j] = ctl_c[j+1].vld;

			fpba_cell #(
				.SIZE_BITS (SIZE_BITS),
				.IDX_W     (IDX_W),
				.CELL_ID   (j)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.fit_mode (fit_mode_q),
				.active   (active[j]),
				.want     (want_bus),
				.ctl_in   (ctl_c[j]),
				.idx_in   (idx_c[j]),
				.size_in  (size_c[j]),
				.ctl_out  (ctl_c[j+1]),
				.idx_out  (idx_c[j+1]),
				.size_out (size_c[j+1]),
				.wr_en    (wr_en),
				.wr_idx   (wr_idx),
				.wr_size  (wr_size),
				.wr_used  (wr_used)
			);
		end
	endgenerate

	// writes: an in-range load at accept, a grant when the record leaves the row
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = IDX_W'(block_index);
		wr_size = want_in;
		wr_used = 1'b0;
		if (state_q == ST_IDLE) begin
			wr_en = accept && (action == fpba_pkg::ACT_LOAD) && in_range;
		end else begin
			wr_en   = tail.vld && !tail.is_read && tail.have;
			wr_idx  = idx_c[PARTITIONS];
			wr_size = size_c[PARTITIONS] - want_q;
			wr_used = 1'b1;
		end
	end

	// result selection
	always_comb begin
		res_fire    = 1'b0;
		res_granted = 1'b0;
		res_idx     = '0;
		res_rem     = '0;
		res_bend    = bend_q;
		if (state_q == ST_IDLE) begin
			res_bend = batch_end;
			case (action)
				fpba_pkg::ACT_LOAD: begin
					res_fire = accept;
					res_idx  = block_index;
					res_rem  = fpba_pkg::AMOUNT_W'(want_in);
				end
				fpba_pkg::ACT_REQ: begin
					res_fire = 1'b0;
				end
				fpba_pkg::ACT_READ: begin
					// out-of-range read answers at once with size zero
					res_fire = accept && !in_range;
					res_idx  = block_index;
				end
				default: begin
					res_fire = accept;
				end
			endcase
		end else if (tail.vld) begin
			res_fire = 1'b1;
			if (tail.is_read) begin
				res_idx = bidx_q;
				res_rem = tail.have ? fpba_pkg::AMOUNT_W'(size_c[PARTITIONS]) : '0;
			end else if (tail.have) begin
				res_granted = 1'b1;
				res_idx     = fpba_pkg::BIDX_W'(idx_c[PARTITIONS]);
				res_rem     = fpba_pkg::AMOUNT_W'(size_c[PARTITIONS] - want_q);
			end
		end
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			fit_mode_q <= fpba_pkg::FIT_FIRST;
			blocks_q   <= '0;
		end else begin
			done_q <= res_fire;
			case (state_q)
				ST_IDLE: begin
					if (ctl_c[0].vld) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tail.vld) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_index)
					fpba_pkg::REG_FIT_MODE: fit_mode_q <= cfg_wdata[fpba_pkg::MODE_W-1:0];
					fpba_pkg::REG_BLOCKS:   blocks_q   <= cfg_wdata[fpba_pkg::BLK_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			want_q <= want_in;
			bidx_q <= block_index;
			bend_q <= batch_end;
		end
		if (res_fire) begin
			granted_q <= res_granted;
			chosen_q  <= res_idx;
			rem_q     <= res_rem;
			bdone_q   <= res_bend;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign chosen_index = chosen_q;
	assign remaining    = rem_q;
	assign batch_done   = bdone_q;

	// at most one record in the row at any time
	a_one_record: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(vld_vec))
		else $error("more than one record in the cell row");

	// a record only leaves the row while the controller waits for it
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.vld |-> state_q == ST_SCAN)
		else $error("record left the row outside a scan");

	// an injected record makes the block busy on the next cycle
	a_inject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[0].vld |=> busy)
		else $error("record injected without going busy");

	// a grant always comes from a search that found a partition
	a_grant_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_fire && res_granted |-> tail.vld && tail.have && !tail.is_read)
		else $error("grant without a found partition");

endmodule
